FILE: hw/rtl/bfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

   localparam int NODE_W     = 6;
   localparam int NODE_CNT_W = 7;
   localparam int DIST_W     = 7;

   localparam logic [DIST_W-1:0]     DIST_UNREACHED = 7'h7F;
   localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 7'd64;
   localparam logic [NODE_W-1:0]     SOURCE_NODE_RST = 6'd0;

   // register index as decoded from the word address
   localparam logic REG_NODE_COUNT  = 1'b0;
   localparam logic REG_SOURCE_NODE = 1'b1;

   typedef struct packed {
      logic [NODE_CNT_W-1:0] node_count;
      logic [NODE_W-1:0]     source_node;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_POP,
      ST_LOADU,
      ST_SCAN,
      ST_ORD,
      ST_OWAIT,
      ST_OSEND
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bfs_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bfs_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module bfs_csr
   import bfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_NODE_COUNT:  cfg_in.node_count  = csr_pwdata[NODE_CNT_W-1:0];
            REG_SOURCE_NODE: cfg_in.source_node = csr_pwdata[NODE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_count  <= NODE_COUNT_RST;
         cfg_ff.source_node <= SOURCE_NODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_NODE_COUNT:  csr_prdata = 32'(cfg_ff.node_count);
         REG_SOURCE_NODE: csr_prdata = 32'(cfg_ff.source_node);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bfs_ctrl
   import bfs_pkg::*;
#(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  cfg_type                cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [NODE_W-1:0] req_from,
   input  wire logic [NODE_W-1:0] req_to,
   input  wire logic              req_last,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [NODE_W-1:0] rsp_node,
   output logic      [DIST_W-1:0] rsp_dist,
   output logic                   rsp_last,
   output logic                   rsp_ovf
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int QW = $clog2(MAX_NODES + 1);
   localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int FW = $clog2(MAX_EDGES + 1);
   localparam int EW = 2 * NW;
   localparam int QDW = NW + DIST_W;

   state_type state_ff, state_in;

   logic [FW-1:0]        fill_ff, fill_in;
   logic                 ovf_ff, ovf_in;
   logic [MAX_NODES-1:0] seen_ff, seen_in;
   logic [QW-1:0]        head_ff, head_in;
   logic [QW-1:0]        tail_ff, tail_in;
   logic [NW-1:0]        u_ff, u_in;
   logic [DIST_W-1:0]    du_ff, du_in;
   logic [FW-1:0]        e_ff, e_in;
   logic                 pend_ff, pend_in;
   logic [NW-1:0]        oidx_ff, oidx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]    onode_ff, onode_in;
   logic [DIST_W-1:0]    odist_ff, odist_in;
   logic                 olast_ff, olast_in;
   logic                 oovf_ff, oovf_in;

   logic [NODE_CNT_W-1:0] n_act;
   logic                  in_ok;
   logic                  src_ok;
   logic                  issue;
   logic                  hit;
   logic                  o_last;
   logic [NW-1:0]         e_from;
   logic [NW-1:0]         e_to;
   logic [DIST_W-1:0]     du_next;

   logic            edge_we;
   logic [AW-1:0]   edge_waddr;
   logic [EW-1:0]   edge_wdata;
   logic [EW-1:0]   edge_rdata;
   logic            q_we;
   logic [NW-1:0]   q_waddr;
   logic [QDW-1:0]  q_wdata;
   logic [QDW-1:0]  q_rdata;
   logic            d_we;
   logic [NW-1:0]   d_waddr;
   logic [DIST_W-1:0] d_wdata;
   logic [DIST_W-1:0] d_rdata;

   bfs_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (edge_wdata),
      .rd_addr (e_ff[AW-1:0]),
      .rd_data (edge_rdata)
   );

   bfs_ram #(.WIDTH(QDW), .DEPTH(MAX_NODES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (head_ff[NW-1:0]),
      .rd_data (q_rdata)
   );

   bfs_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_addr (oidx_ff),
      .rd_data (d_rdata)
   );

   always_comb begin
      if (cfg.node_count == '0) begin
         n_act = NODE_CNT_W'(1);
      end else if (cfg.node_count > NODE_CNT_W'(MAX_NODES)) begin
         n_act = NODE_CNT_W'(MAX_NODES);
      end else begin
         n_act = cfg.node_count;
      end
   end

   assign in_ok   = (NODE_CNT_W'(req_from) < n_act) && (NODE_CNT_W'(req_to) < n_act);
   assign src_ok  = NODE_CNT_W'(cfg.source_node) < n_act;
   assign issue   = e_ff < fill_ff;
   assign e_from  = edge_rdata[EW-1:NW];
   assign e_to    = edge_rdata[NW-1:0];
   assign hit     = pend_ff && (e_from == u_ff) && (NODE_CNT_W'(e_to) < n_act)
                    && !seen_ff[e_to];
   assign du_next = du_ff + DIST_W'(1);
   assign o_last  = (NODE_CNT_W'(oidx_ff) + NODE_CNT_W'(1)) == n_act;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: state_in = ST_POP;
         ST_POP: begin
            if (head_ff < tail_ff) begin
               state_in = ST_LOADU;
            end else begin
               state_in = ST_ORD;
            end
         end
         ST_LOADU: state_in = ST_SCAN;
         ST_SCAN: begin
            if (!issue && !pend_ff) begin
               state_in = ST_POP;
            end
         end
         ST_ORD:   state_in = ST_OWAIT;
         ST_OWAIT: state_in = ST_OSEND;
         ST_OSEND: begin
            if (rsp_ready) begin
               state_in = olast_ff ? ST_LOAD : ST_ORD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      seen_in      = seen_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      u_in         = u_ff;
      du_in        = du_ff;
      e_in         = e_ff;
      pend_in      = pend_ff;
      oidx_in      = oidx_ff;
      rsp_valid_in = rsp_valid_ff;
      onode_in     = onode_ff;
      odist_in     = odist_ff;
      olast_in     = olast_ff;
      oovf_in      = oovf_ff;
      req_ready    = 1'b0;
      edge_we      = 1'b0;
      edge_waddr   = fill_ff[AW-1:0];
      edge_wdata   = {req_from[NW-1:0], req_to[NW-1:0]};
      q_we         = 1'b0;
      q_waddr      = tail_ff[NW-1:0];
      q_wdata      = {e_to, du_next};
      d_we         = 1'b0;
      d_waddr      = e_to;
      d_wdata      = du_next;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid && in_ok) begin
               if (fill_ff < FW'(MAX_EDGES)) begin
                  edge_we = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_INIT: begin
            seen_in = '0;
            head_in = '0;
            tail_in = '0;
            if (src_ok) begin
               seen_in[cfg.source_node[NW-1:0]] = 1'b1;
               q_we    = 1'b1;
               q_waddr = '0;
               q_wdata = {cfg.source_node[NW-1:0], DIST_W'(0)};
               d_we    = 1'b1;
               d_waddr = cfg.source_node[NW-1:0];
               d_wdata = '0;
               tail_in = QW'(1);
            end
         end
         ST_POP: begin
            oidx_in = '0;
            if (head_ff < tail_ff) begin
               head_in = head_ff + QW'(1);
            end
         end
         ST_LOADU: begin
            u_in    = q_rdata[QDW-1:DIST_W];
            du_in   = q_rdata[DIST_W-1:0];
            e_in    = '0;
            pend_in = 1'b0;
         end
         ST_SCAN: begin
            pend_in = issue;
            if (issue) begin
               e_in = e_ff + FW'(1);
            end
            if (hit) begin
               seen_in[e_to] = 1'b1;
               d_we    = 1'b1;
               q_we    = 1'b1;
               tail_in = tail_ff + QW'(1);
            end
         end
         ST_ORD: begin
            rsp_valid_in = 1'b0;
         end
         ST_OWAIT: begin
            rsp_valid_in = 1'b1;
            onode_in     = NODE_W'(oidx_ff);
            odist_in     = seen_ff[oidx_ff] ? d_rdata : DIST_UNREACHED;
            olast_in     = o_last;
            oovf_in      = ovf_ff;
         end
         ST_OSEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (olast_ff) begin
                  fill_in = '0;
                  ovf_in  = 1'b0;
               end else begin
                  oidx_in = oidx_ff + NW'(1);
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         seen_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         e_ff         <= '0;
         pend_ff      <= 1'b0;
         oidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         seen_ff      <= seen_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         e_ff         <= e_in;
         pend_ff      <= pend_in;
         oidx_ff      <= oidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      du_ff    <= du_in;
      onode_ff <= onode_in;
      odist_ff <= odist_in;
      olast_ff <= olast_in;
      oovf_ff  <= oovf_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_node  = onode_ff;
   assign rsp_dist  = odist_ff;
   assign rsp_last  = olast_ff;
   assign rsp_ovf   = oovf_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bfs_unweighted_shortest_path_top.sv
// edge entries load at one per cycle while the block waits for the last entry
// search: the stored edge list is walked in full once per dequeued node,
// read through the edge memory's single read port
// results: one per node in index order, read out of the distance memory
// not ready for entries from the last entry until the final result is taken
// synchronous active-high reset: empty edge list, node_count 64, source_node 0
`timescale 1ns / 1ps
`default_nettype none

module bfs_unweighted_shortest_path_top
   import bfs_pkg::*;
#(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // from_node, to_node
   input  wire logic        req_tlast,   // last_edge
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // node_index, hop_distance
   output logic             rsp_tlast,   // last_node
   output logic      [0:0]  rsp_tuser,   // edge_overflow
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type           cfg;
   logic [NODE_W-1:0] rsp_node;
   logic [DIST_W-1:0] rsp_dist;
   logic              rsp_ovf;

   bfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bfs_ctrl #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_from  (req_tdata[NODE_W-1:0]),
      .req_to    (req_tdata[2*NODE_W-1:NODE_W]),
      .req_last  (req_tlast),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_node  (rsp_node),
      .rsp_dist  (rsp_dist),
      .rsp_last  (rsp_tlast),
      .rsp_ovf   (rsp_ovf)
   );

   assign rsp_tdata = {3'b000, rsp_dist, rsp_node};
   assign rsp_tuser = rsp_ovf;

endmodule

`default_nettype wire

FILE: dv/tb_bfs_unweighted_shortest_path_top.sv
`timescale 1ns / 1ps

module tb_bfs_unweighted_shortest_path_top;
   import bfs_pkg::*;

   localparam int MAX_NODES      = 64;
   localparam int MAX_EDGES      = 1024;
   localparam int RANDOM_ENTRIES = 430;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int PLAN_ROWS      = 28;

   typedef struct {
      logic [5:0] node_index;
      logic [6:0] hop_distance;
      logic       last_node;
      logic       edge_overflow;
   } hop_rsp_type;

   typedef struct {
      logic [5:0] from_node;
      logic [5:0] to_node;
      logic       last_edge;
      bit         typed;
      logic [6:0] t_dist;
   } pending_entry_type;

   typedef enum bit {ROW_ENTRY, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic         reg_sel;
      logic [6:0]   wr_value;
      logic [5:0]   from_node;
      logic [5:0]   to_node;
      logic         last_edge;
      bit           typed;
      logic [6:0]   t_dist;
   } plan_row_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata    = '0;   // from_node, to_node
   logic        req_tlast    = 1'b0; // last_edge
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [15:0] rsp_tdata;           // node_index, hop_distance
   logic        rsp_tlast;           // last_node
   logic [0:0]  rsp_tuser;           // edge_overflow
   logic        csr_psel     = 1'b0;
   logic        csr_penable  = 1'b0;
   logic        csr_pwrite   = 1'b0;
   logic [2:0]  csr_paddr    = '0;
   logic [31:0] csr_pwdata   = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow of the block state
   logic [11:0]    edge_mem [MAX_EDGES];
   int             edge_cnt       = 0;
   bit             ovf_seen       = 1'b0;
   logic [6:0]     cfg_node_count = NODE_COUNT_RST;
   logic [5:0]     cfg_source     = SOURCE_NODE_RST;

   hop_rsp_type       expected_hops [$];
   pending_entry_type sent_q [$];
   int             mismatches      = 0;
   int             results_checked = 0;
   int             graphs_searched = 0;
   int             entries_sent    = 0;
   int             idle_cycles     = 0;
   bit             req_calm        = 1'b0;
   bit             rsp_calm        = 1'b0;
   int             rsp_hold        = 0;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd0,  6'd63, 1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd63, 6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd0,  6'd63, 1'b1, 1'b0, 7'd0},
      '{ROW_WRITE, REG_NODE_COUNT,  7'd1,   6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd0,  6'd0,  1'b1, 1'b1, 7'd0},
      '{ROW_WRITE, REG_SOURCE_NODE, 7'd63,  6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd0,  6'd0,  1'b1, 1'b1, DIST_UNREACHED},
      '{ROW_WRITE, REG_NODE_COUNT,  7'd0,   6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_WRITE, REG_SOURCE_NODE, 7'd0,   6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd63, 6'd63, 1'b1, 1'b1, 7'd0},
      '{ROW_WRITE, REG_NODE_COUNT,  7'd127, 6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_WRITE, REG_SOURCE_NODE, 7'd63,  6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd63, 6'd1,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd1,  6'd2,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd2,  6'd2,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd62, 6'd63, 1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd1,  6'd62, 1'b1, 1'b0, 7'd0},
      '{ROW_WRITE, REG_NODE_COUNT,  7'd4,   6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_WRITE, REG_SOURCE_NODE, 7'd0,   6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd0,  6'd1,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd1,  6'd2,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd2,  6'd3,  1'b0, 1'b0, 7'd0},
      '{ROW_WRITE, REG_NODE_COUNT,  7'd3,   6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd3,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd0,  6'd2,  1'b1, 1'b0, 7'd0},
      '{ROW_WRITE, REG_NODE_COUNT,  7'd64,  6'd0,  6'd0,  1'b0, 1'b0, 7'd0},
      '{ROW_ENTRY, REG_NODE_COUNT,  7'd0,   6'd63, 6'd62, 1'b1, 1'b0, 7'd0}
   };

   bfs_unweighted_shortest_path_top #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stores one entry and, on the last one, runs the search and lists the distances
   function automatic void predict_hops(input logic [5:0] from_n, input logic [5:0] to_n,
                                        input logic last_e, ref hop_rsp_type hops[$]);
      int         n;
      int         head;
      int         tail;
      logic [5:0] u;
      logic [5:0] f;
      logic [5:0] t;
      bit         seen [64];
      logic [6:0] hop_dist [64];
      logic [5:0] frontier [64];
      n = (cfg_node_count == 0) ? 1 : (cfg_node_count > MAX_NODES) ? MAX_NODES
                                                                     : int'(cfg_node_count);
      if (from_n < n && to_n < n) begin
         if (edge_cnt < MAX_EDGES) begin
            edge_mem[edge_cnt] = {from_n, to_n};
            edge_cnt++;
         end else begin
            ovf_seen = 1'b1;
         end
      end
      if (!last_e) return;
      for (int i = 0; i < 64; i++) begin
         seen[i] = 1'b0;
         hop_dist[i] = DIST_UNREACHED;
      end
      head = 0;
      tail = 0;
      if (cfg_source < n) begin
         seen[cfg_source] = 1'b1;
         hop_dist[cfg_source] = 7'd0;
         frontier[0] = cfg_source;
         tail = 1;
      end
      while (head < tail) begin
         u = frontier[head];
         head++;
         for (int e = 0; e < edge_cnt; e++) begin
            f = edge_mem[e][11:6];
            t = edge_mem[e][5:0];
            if (f == u && t < n && !seen[t]) begin
               seen[t] = 1'b1;
               hop_dist[t] = hop_dist[u] + 7'd1;
               if (tail < 64) begin
                  frontier[tail] = t;
                  tail++;
               end
            end
         end
      end
      for (int i = 0; i < n; i++)
         hops = {hops, hop_rsp_type'{6'(i), hop_dist[i], i == n - 1, ovf_seen}};
      edge_cnt = 0;
      ovf_seen = 1'b0;
   endfunction

   task automatic send_entry(input logic [5:0] from_n, input logic [5:0] to_n,
                             input logic last_e, input bit typed, input logic [6:0] t_dist);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, to_n, from_n};
      req_tlast  <= last_e;
      sent_q = {sent_q, pending_entry_type'{from_n, to_n, last_e, typed, t_dist}};
      do @(posedge clock); while (!req_tready);
      entries_sent++;
   endtask

   // register writes only once all distances are out and the last entry has settled
   task automatic write_reg(input logic reg_sel, input logic [6:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_hops.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(posedge clock) begin : scoreboard
      pending_entry_type ent;
      hop_rsp_type       want;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_NODE_COUNT) cfg_node_count = csr_pwdata[6:0];
            else cfg_source = csr_pwdata[5:0];
         end
         if (req_tvalid && req_tready) begin
            ent = sent_q.pop_front();
            if (ent.typed) begin
               hop_rsp_type scratch [$];
               predict_hops(ent.from_node, ent.to_node, ent.last_edge, scratch);
               expected_hops = {expected_hops,
                                hop_rsp_type'{6'd0, ent.t_dist, 1'b1, 1'b0}};
            end else begin
               predict_hops(ent.from_node, ent.to_node, ent.last_edge, expected_hops);
            end
            if (ent.last_edge) graphs_searched++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hops.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: node %0d hop %0d last %0b ovf %0b",
                           rsp_tdata[5:0], $signed(rsp_tdata[12:6]), rsp_tlast, rsp_tuser[0]);
            end else begin
               want = expected_hops.pop_front();
               results_checked++;
               if (rsp_tdata[5:0] !== want.node_index ||
                   rsp_tdata[12:6] !== want.hop_distance ||
                   rsp_tlast !== want.last_node || rsp_tuser[0] !== want.edge_overflow) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("mismatch: exp node %0d hop %0d last %0b ovf %0b, ",
                            want.node_index, $signed(want.hop_distance), want.last_node,
                            want.edge_overflow);
                     $display("got node %0d hop %0d last %0b ovf %0b",
                              rsp_tdata[5:0], $signed(rsp_tdata[12:6]), rsp_tlast,
                              rsp_tuser[0]);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int         rnd_sent;
      int         span;
      int         eff;
      int         src;
      int         edges;
      int         cut;
      int         cur;
      int         from_v;
      int         to_v;
      int         pick;
      logic [6:0] nc_value;
      int         chain_order [$];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_WRITE)
            write_reg(plan[r].reg_sel, plan[r].wr_value);
         else
            send_entry(plan[r].from_node, plan[r].to_node, plan[r].last_edge,
                       plan[r].typed, plan[r].t_dist);
      end

      // more entries than the edge memory holds, on a two-node graph
      write_reg(REG_NODE_COUNT, 7'd2);
      write_reg(REG_SOURCE_NODE, 7'd0);
      for (int k = 0; k < MAX_EDGES + 6; k++)
         send_entry(6'(k % 2), 6'((k + 1) % 2), k == MAX_EDGES + 5, 1'b0, 7'd0);

      // shuffled chain through all nodes, deepest distance
      write_reg(REG_NODE_COUNT, 7'd64);
      for (int k = 0; k < 63; k++) chain_order = {chain_order, k};
      chain_order.shuffle();
      for (int k = 0; k < 63; k++)
         send_entry(6'(chain_order[k]), 6'(chain_order[k] + 1), k == 62, 1'b0, 7'd0);

      rnd_sent = 0;
      eff = 64;
      while (rnd_sent < RANDOM_ENTRIES) begin
         if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 19);
            nc_value = (pick == 0) ? 7'd0 :
                       (pick == 1) ? 7'($urandom_range(65, 127)) :
                       (pick < 5)  ? 7'($urandom_range(17, 64)) : 7'($urandom_range(1, 16));
            write_reg(REG_NODE_COUNT, nc_value);
            eff = (nc_value == 0) ? 1 : (nc_value > 64) ? 64 : int'(nc_value);
         end
         src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, eff - 1);
         write_reg(REG_SOURCE_NODE, 7'(src));
         edges = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, edges) : 0;
         span = eff;
         cur = src;
         for (int j = 0; j < edges; j++) begin
            if (cut != 0 && j == cut) begin
               // node count set to at most its current value while entries are stored
               nc_value = 7'($urandom_range(1, eff));
               write_reg(REG_NODE_COUNT, nc_value);
               eff = int'(nc_value);
            end
            if ($urandom_range(0, 7) == 0) begin
               from_v = $urandom_range(0, 63);
               to_v = $urandom_range(0, 63);
            end else begin
               from_v = ($urandom_range(0, 1) == 1 && cur < span) ? cur
                                                                  : $urandom_range(0, span - 1);
               to_v = $urandom_range(0, span - 1);
            end
            cur = to_v;
            send_entry(6'(from_v), 6'(to_v), j == edges - 1, 1'b0, 7'd0);
            rnd_sent++;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_hops.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d graphs searched from %0d edge entries, %0d node distances checked",
               graphs_searched, entries_sent, results_checked);
      $display("node counts 0 to 127, outside sources, edge overflow, 63-hop chain; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bfs_pkg.sv
hw/rtl/bfs_ram.sv
hw/rtl/bfs_csr.sv
hw/rtl/bfs_ctrl.sv
hw/rtl/bfs_unweighted_shortest_path_top.sv
dv/tb_bfs_unweighted_shortest_path_top.sv
